[src/b62_pkg.sv]
package b62_pkg;

    // digit layout of a 64-bit magnitude in base 62
    localparam int DIGIT_COUNT = 11;
    localparam int IDX_W       = 4;
    localparam int MAG_W       = 64;
    localparam int DIGIT_W     = 6;
    localparam int SLICE_W     = 3;
    localparam int SLICE_MAX   = (1 << SLICE_W) - 1;
    localparam int CMP_W       = MAG_W + SLICE_W;
    localparam int CHAR_W      = 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ascii codes
    localparam logic [CHAR_W-1:0] MINUS_CH  = 8'h2D;
    localparam logic [CHAR_W-1:0] ZERO_CH   = 8'h30;
    localparam logic [CHAR_W-1:0] UPPER_A_CH = 8'h41;
    localparam logic [CHAR_W-1:0] LOWER_A_CH = 8'h61;

    typedef logic [IDX_W-1:0] digit_idx_t;

    // one queued transaction: sign and magnitude
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // powers of 62 that fit in 64 bits
    function automatic logic [MAG_W-1:0] pow62(digit_idx_t i);
        logic [MAG_W-1:0] p;
        unique case (i)
            4'd1:    p = 64'd62;
            4'd2:    p = 64'd3844;
            4'd3:    p = 64'd238328;
            4'd4:    p = 64'd14776336;
            4'd5:    p = 64'd916132832;
            4'd6:    p = 64'd56800235584;
            4'd7:    p = 64'd3521614606208;
            4'd8:    p = 64'd218340105584896;
            4'd9:    p = 64'd13537086546263552;
            4'd10:   p = 64'd839299365868340224;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

    // j * 62^i, scaled by 8 for the upper slice of a digit
    function automatic logic [CMP_W-1:0] step_threshold(digit_idx_t i,
                                                         logic [SLICE_W-1:0] j,
                                                         logic upper);
        logic [CMP_W-1:0] p;
        p = CMP_W'(pow62(i)) * CMP_W'(j);
        if (upper)
        begin
            p = p << SLICE_W;
        end
        return p;
    endfunction

    // base-62 digit to ascii
    function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10))
        begin
            c = ZERO_CH + CHAR_W'(d);
        end
        else if (d < DIGIT_W'(36))
        begin
            c = UPPER_A_CH + CHAR_W'(d) - CHAR_W'(10);
        end
        else
        begin
            c = LOWER_A_CH + CHAR_W'(d) - CHAR_W'(36);
        end
        return c;
    endfunction

endpackage

[src/b62_queue.sv]
module b62_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b62_pkg::entry_t    wr_data,
    input  logic               pop,
    output b62_pkg::entry_t    rd_data,
    output b62_pkg::q_status_t stat
);
    import b62_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[src/b62_front.sv]
module b62_front (
    input  logic                      start,
    input  logic signed [63:0]        value,
    input  b62_pkg::q_status_t        q_stat,
    output logic                      busy,
    output logic                      push,
    output b62_pkg::entry_t           entry
);
    import b62_pkg::*;

    logic [MAG_W-1:0] raw;

    // accept whenever the queue has room
    assign busy = q_stat.full;
    assign push = start && !q_stat.full;

    // split into sign and magnitude; the most negative value wraps to 2^63
    assign raw       = $unsigned(value);
    assign entry.neg = raw[MAG_W-1];
    assign entry.mag = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;

endmodule

[src/b62_digit.sv]
module b62_digit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  b62_pkg::q_status_t         q_stat,
    input  b62_pkg::entry_t            q_data,
    output logic                       pop,
    output logic                       strobe,
    output logic [b62_pkg::CHAR_W-1:0] ch,
    output logic                       last
);
    import b62_pkg::*;

    logic                active_reg, active_next;
    logic                sign_reg, sign_next;
    logic                skip_reg, skip_next;
    logic                phase_reg, phase_next;
    digit_idx_t          idx_reg, idx_next;
    logic [SLICE_W-1:0]  hi_reg, hi_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                strobe_reg, strobe_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                last_reg, last_next;

    logic [CMP_W-1:0]    thr [SLICE_MAX + 1];
    logic [SLICE_MAX:0]  ge;
    logic [SLICE_W-1:0]  sel;
    logic [CMP_W-1:0]    rem;
    logic [DIGIT_W-1:0]  digit;
    logic                finish;
    logic                suppress;

    // three bits of the current digit per cycle: parallel compares against
    // the multiples of the current power of 62
    always_comb
    begin
        thr[0] = '0;
        ge[0]  = 1'b1;
        for (int k = 1; k <= SLICE_MAX; k++)
        begin
            thr[k] = step_threshold(idx_reg, SLICE_W'(k), !phase_reg);
            ge[k]  = (thr[k] <= CMP_W'(mag_reg));
        end
        sel = '0;
        for (int k = 1; k <= SLICE_MAX; k++)
        begin
            if (ge[k])
            begin
                sel = SLICE_W'(k);
            end
        end
    end

    assign rem      = CMP_W'(mag_reg) - thr[sel];
    assign digit    = {hi_reg, sel};
    assign finish   = active_reg && phase_reg && (idx_reg == '0);
    assign suppress = skip_reg && (digit == '0) && (idx_reg != '0);
    assign pop      = !q_stat.empty && (!active_reg || finish);

    // digit sequencer and output register
    always_comb
    begin
        active_next = active_reg;
        sign_next   = sign_reg;
        skip_next   = skip_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        mag_next    = mag_reg;
        strobe_next = 1'b0;
        ch_next     = ch_reg;
        last_next   = last_reg;

        if (active_reg)
        begin
            mag_next = rem[MAG_W-1:0];
            if (!phase_reg)
            begin
                hi_next    = sel;
                phase_next = 1'b1;
                // minus sign goes out while the first digit is worked on
                if (sign_reg)
                begin
                    strobe_next = 1'b1;
                    ch_next     = MINUS_CH;
                    last_next   = 1'b0;
                    sign_next   = 1'b0;
                end
            end
            else
            begin
                phase_next = 1'b0;
                if (!suppress)
                begin
                    strobe_next = 1'b1;
                    ch_next     = digit_char(digit);
                    last_next   = (idx_reg == '0);
                end
                skip_next = suppress;
                idx_next  = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    active_next = 1'b0;
                end
            end
        end

        // load the next transaction from the queue
        if (pop)
        begin
            active_next = 1'b1;
            sign_next   = q_data.neg;
            mag_next    = q_data.mag;
            idx_next    = IDX_W'(DIGIT_COUNT - 1);
            phase_next  = 1'b0;
            skip_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sign_reg   <= 1'b0;
            skip_reg   <= 1'b0;
            phase_reg  <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            sign_reg   <= sign_next;
            skip_reg   <= skip_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        mag_reg  <= mag_next;
        ch_reg   <= ch_next;
        last_reg <= last_next;
    end

    assign strobe = strobe_reg;
    assign ch     = ch_reg;
    assign last   = last_reg;

endmodule

[src/base62_int64_to_text.sv]
// Signed 64-bit to base-62 text. A transaction is taken when start is high
// and busy is low; the text then leaves one character per strobe, most
// significant digit first, '-' ahead of a negative value, last marking the
// final character. Strobed characters cannot be held off by the receiver.
// The digit unit resolves three bits of a base-62 digit per cycle, so each
// of the 11 digits is worked in an upper and a lower slice step, and one
// value is finished before the next is loaded from the queue. A minus sign
// is strobed while the first digit is worked on, and suppressed leading
// zero digits still take both of their slice steps. A two-entry queue
// sits between the accepting front and the digit unit, so up to two
// further values are taken back to back while one is being converted;
// busy is high only while that queue is full.
module base62_int64_to_text (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [63:0]         value,
    output logic                       busy,
    output logic                       strobe,
    output logic [b62_pkg::CHAR_W-1:0] ch,
    output logic                       last
);
    import b62_pkg::*;

    logic      push;
    logic      pop;
    entry_t    wr_entry;
    entry_t    rd_entry;
    q_status_t q_stat;

    // accept and split sign from magnitude
    b62_front u_front (
        .start  (start),
        .value  (value),
        .q_stat (q_stat),
        .busy   (busy),
        .push   (push),
        .entry  (wr_entry)
    );

    // decoupling queue
    b62_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .stat    (q_stat)
    );

    // digit extraction and character output
    b62_digit u_digit (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (rd_entry),
        .pop    (pop),
        .strobe (strobe),
        .ch     (ch),
        .last   (last)
    );

endmodule

[src/b62_checker.sv]
module b62_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       strobe,
    input logic [b62_pkg::CHAR_W-1:0] ch,
    input logic                       last
);
    import b62_pkg::*;

    // busy only rises after a transaction was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted transaction");

    // minus sign is never the final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && ch == MINUS_CH) |-> !last)
        else $error("minus sign marked as last");

    // two minus signs never come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && ch == MINUS_CH) |=> !(strobe && ch == MINUS_CH))
        else $error("minus sign repeated");

    // every strobed character is a sign or a base-62 digit
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (ch == MINUS_CH
                    || (ch >= 8'h30 && ch <= 8'h39)
                    || (ch >= 8'h41 && ch <= 8'h5A)
                    || (ch >= 8'h61 && ch <= 8'h7A)))
        else $error("character outside the base-62 alphabet");

endmodule

bind base62_int64_to_text b62_checker u_b62_checker (.*);

[bench/tb_base62_int64_to_text.sv]
`timescale 1ns / 1ps

module tb_base62_int64_to_text;

    import b62_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 160;
    localparam int MAX_PRINTED  = 40;

    // one expected character of the text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [63:0] value = '0;
    logic               busy;
    logic               strobe;
    logic [CHAR_W-1:0]  ch;
    logic               last;

    logic signed [63:0] pending_values[$];
    text_char_t         text_expected[$];
    text_char_t         exp_char;
    int                 sender_idle_pct = 23;
    logic               took_item = 1'b0;
    int                 stall_cycles = 0;
    int                 mismatches = 0;
    int                 values_sent = 0;
    int                 negatives_sent = 0;
    int                 chars_checked = 0;

    base62_int64_to_text uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value),
        .busy   (busy),
        .strobe (strobe),
        .ch     (ch),
        .last   (last)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatches++;
    endtask

    // base-62 text of one value, pushed onto the expected characters
    function automatic void predict_text(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] place;
        logic [63:0] dig;
        logic        leading;
        text_char_t  c;
        mag = v[63] ? (~v + 64'd1) : v;
        leading = 1'b1;
        if (v[63])
        begin
            c.ch = MINUS_CH;
            c.last = 1'b0;
            text_expected.push_back(c);
        end
        for (int i = DIGIT_COUNT - 1; i >= 0; i--)
        begin
            place = 64'd1;
            for (int k = 0; k < i; k++)
            begin
                place = place * 64'd62;
            end
            dig = mag / place;
            mag = mag - dig * place;
            if (leading && dig == 0 && i > 0)
            begin
                continue;
            end
            leading = 1'b0;
            if (dig < 10)
            begin
                c.ch = ZERO_CH + CHAR_W'(dig);
            end
            else if (dig < 36)
            begin
                c.ch = UPPER_A_CH + CHAR_W'(dig - 10);
            end
            else
            begin
                c.ch = LOWER_A_CH + CHAR_W'(dig - 36);
            end
            c.last = (i == 0);
            text_expected.push_back(c);
        end
    endfunction

    // random value with a mix of shapes: full width, n-digit, near powers, small, near limits
    function automatic logic signed [63:0] random_value();
        logic signed [63:0] v;
        logic [63:0]        place;
        int                 kind;
        int                 ndig;
        kind = $urandom_range(0, 9);
        v = '0;
        if (kind <= 2)
        begin
            v = {$urandom, $urandom};
        end
        else if (kind <= 6)
        begin
            ndig = $urandom_range(1, 10);
            place = 64'd1;
            for (int i = 0; i < ndig; i++)
            begin
                if (i == ndig - 1 && ndig > 1)
                begin
                    v = v + place * 64'($urandom_range(1, 61));
                end
                else
                begin
                    v = v + place * 64'($urandom_range(0, 61));
                end
                place = place * 64'd62;
            end
        end
        else if (kind == 7)
        begin
            place = 64'd1;
            ndig = $urandom_range(0, 10);
            for (int i = 0; i < ndig; i++)
            begin
                place = place * 64'd62;
            end
            v = place + 64'($urandom_range(0, 2)) - 64'd1;
        end
        else if (kind == 8)
        begin
            v = 64'($urandom_range(0, 200));
        end
        else
        begin
            v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
        end
        if (kind >= 3 && $urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return v;
    endfunction

    // driver: offer the next pending value once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || took_item))
        begin
            if (pending_values.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                value <= pending_values.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on acceptance, check each strobed character, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_item = start && !busy;
            if (took_item)
            begin
                predict_text(value);
                values_sent++;
                if (value < 0)
                begin
                    negatives_sent++;
                end
            end
            if (strobe)
            begin
                if (text_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b", ch, last));
                end
                else
                begin
                    exp_char = text_expected.pop_front();
                    chars_checked++;
                    if (ch !== exp_char.ch)
                    begin
                        report_mismatch($sformatf("ch 0x%02h, expected 0x%02h",
                                                  ch, exp_char.ch));
                    end
                    if (last !== exp_char.last)
                    begin
                        report_mismatch($sformatf("last %0b, expected %0b on ch 0x%02h",
                                                  last, exp_char.last, exp_char.ch));
                    end
                end
            end
            if (took_item || strobe)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus and phase control
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero, digit class edges, powers of 62, limits of int64
        pending_values.push_back(64'sd0);
        pending_values.push_back(64'sd1);
        pending_values.push_back(-64'sd1);
        pending_values.push_back(64'sd9);
        pending_values.push_back(64'sd10);
        pending_values.push_back(64'sd35);
        pending_values.push_back(64'sd36);
        pending_values.push_back(64'sd61);
        pending_values.push_back(64'sd62);
        pending_values.push_back(-64'sd62);
        pending_values.push_back(64'sd3843);
        pending_values.push_back(64'sd3844);
        pending_values.push_back(64'sd839299365868340223);
        pending_values.push_back(64'sd839299365868340224);
        pending_values.push_back(-64'sd839299365868340224);
        pending_values.push_back(64'sh7FFF_FFFF_FFFF_FFFF);
        pending_values.push_back(64'sh8000_0000_0000_0000);
        pending_values.push_back(64'sh8000_0000_0000_0001);
        pending_values.push_back(64'shAAAA_AAAA_AAAA_AAAA);
        pending_values.push_back(64'sh5555_5555_5555_5555);

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 52 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pending_values.push_back(random_value());
            end
            while (pending_values.size() != 0 || start)
            begin
                @(posedge clk);
            end
        end

        // drain remaining text
        while (text_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values (%0d negative), %0d characters checked",
                 values_sent, negatives_sent, chars_checked);
        $display("Pacing: sender idle 23%%, then 52%%, then back to back; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && text_expected.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
